>>> hw/rtl/dup_pkg.sv
// Shared types and constants for the decimal serial number printer.
package dup_pkg;

    // Character buffer
    localparam int BUFFER_DEPTH = 12;
    localparam int BUF_IDX_W    = $clog2(BUFFER_DEPTH);
    localparam int PTR_W        = 5;

    // Field widths
    localparam int NUM_W   = 32;
    localparam int DIV_W   = 16;
    localparam int IVL_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int FRAME_W = 10;
    localparam int BIDX_W  = 4;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DIVISOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_BIT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [DIV_W-1:0] DIVISOR_RST  = 16'd104;
    localparam logic [IVL_W-1:0] INTERVAL_RST = 5'd21;

    // Sequencer phases
    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_SEND   = 2'd2;

    // Frame and character constants
    localparam logic [BIDX_W-1:0]  LAST_BIT    = 4'd9;
    localparam logic [FRAME_W-1:0] FRAME_IDLE  = 10'b00_0000_0001;
    localparam logic [CHAR_W-1:0]  CHAR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;

    // Reciprocal of ten for the quotient: q = (v * RECIP10) >> RECIP_SHIFT
    localparam logic [NUM_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    // Live configuration
    typedef struct packed {
        logic [DIV_W-1:0] bit_divisor;
        logic [IVL_W-1:0] interval_bit;
    } cfg_t;

endpackage

>>> hw/rtl/decimal_uart_number_printer.sv
// Top level: handshakes, configuration registers and the line-level result register.
// Latency: the line level for an accepted tick is registered and offered in the cycle after acceptance.
// Throughput: one tick per cycle while the output side takes a beat every cycle; a level
// left waiting holds the input until it is taken.
// Reset: waiting phase, counter zero, frame idle high, divisor 104, interval bit 21.
// The character buffer has no reset; only entries written for the current number are sent.
module decimal_uart_number_printer
    import dup_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // tick input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [NUM_W-1:0]     number_sample,
    // line level output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 tx_line,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIV_W-1:0]     cfg_data
);

    cfg_t cfg_reg;
    logic out_valid_reg;
    logic tx_line_reg;
    logic step;
    logic tx_next;

    // Accept a tick whenever the result slot is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    dup_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .number_sample (number_sample),
        .cfg           (cfg_reg),
        .tx_next       (tx_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_divisor  <= DIVISOR_RST;
            cfg_reg.interval_bit <= INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BIT_DIVISOR:  cfg_reg.bit_divisor  <= cfg_data;
                CFG_INTERVAL_BIT: cfg_reg.interval_bit <= cfg_data[IVL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Result beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tx_line_reg <= tx_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_line   = tx_line_reg;

endmodule

>>> hw/rtl/dup_div10.sv
// Divide-by-ten unit: quotient by reciprocal multiply, remainder by shift-add.
module dup_div10
    import dup_pkg::*;
(
    input  logic [NUM_W-1:0] value,
    output logic [NUM_W-1:0] quotient,
    output logic [3:0]       remainder
);

    logic [2*NUM_W-1:0] product;
    logic [NUM_W-1:0]   times_ten;
    logic [NUM_W-1:0]   diff;

    // Exact for every 32-bit value
    assign product   = {{NUM_W{1'b0}}, value} * {{NUM_W{1'b0}}, RECIP10};
    assign quotient  = NUM_W'(product >> RECIP_SHIFT);

    // q*10 = q*8 + q*2; the remainder fits in four bits
    assign times_ten = (quotient << 3) + (quotient << 1);
    assign diff      = value - times_ten;
    assign remainder = diff[3:0];

endmodule

>>> hw/rtl/dup_core.sv
// Sequencer: wait timer, digit generation, character buffer and frame shifter.
module dup_core
    import dup_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [NUM_W-1:0] number_sample,
    input  cfg_t             cfg,
    output logic             tx_next
);

    logic [1:0]         phase_reg,  phase_next;
    logic [NUM_W-1:0]   tick_reg,   tick_next;
    logic [FRAME_W-1:0] frame_reg,  frame_next;
    logic [BIDX_W-1:0]  bidx_reg,   bidx_next;
    logic [PTR_W-1:0]   ptr_reg,    ptr_next;
    logic [NUM_W-1:0]   value_reg,  value_next;

    logic [CHAR_W-1:0]  char_buf_reg [BUFFER_DEPTH];

    logic [NUM_W-1:0]   tick_inc;
    logic [NUM_W-1:0]   divisor_ext;
    logic [NUM_W-1:0]   quotient;
    logic [3:0]         remainder;
    logic               ptr_in_range;
    logic [CHAR_W-1:0]  rd_char;
    logic               wr_capture;
    logic               wr_zero;
    logic               wr_digit;
    logic [CHAR_W-1:0]  digit_char;

    dup_div10 u_div10 (
        .value     (value_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign tick_inc     = tick_reg + NUM_W'(1);
    assign divisor_ext  = {{(NUM_W-DIV_W){1'b0}}, cfg.bit_divisor};
    assign ptr_in_range = (ptr_reg < PTR_W'(BUFFER_DEPTH));
    assign rd_char      = ptr_in_range ? char_buf_reg[ptr_reg[BUF_IDX_W-1:0]]
                                       : '0;
    assign digit_char   = CHAR_ZERO + {4'h0, remainder};

    // Next-state logic for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        frame_next = frame_reg;
        bidx_next  = bidx_reg;
        ptr_next   = ptr_reg;
        value_next = value_reg;
        wr_capture = 1'b0;
        wr_zero    = 1'b0;
        wr_digit   = 1'b0;
        case (phase_reg)
            PH_WAIT:
            begin
                tick_next = tick_inc;
                if (tick_inc[cfg.interval_bit])
                begin
                    value_next = number_sample;
                    wr_capture = 1'b1;
                    phase_next = PH_DIGITS;
                    if (number_sample == '0)
                    begin
                        wr_zero  = 1'b1;
                        ptr_next = PTR_W'(2);
                    end
                    else
                    begin
                        ptr_next = PTR_W'(1);
                    end
                end
            end
            PH_DIGITS:
            begin
                if (value_reg != '0)
                begin
                    value_next = quotient;
                    wr_digit   = 1'b1;
                    ptr_next   = ptr_reg + PTR_W'(1);
                end
                else
                begin
                    tick_next  = divisor_ext;
                    bidx_next  = LAST_BIT;
                    ptr_next   = ptr_reg - PTR_W'(1);
                    phase_next = PH_SEND;
                end
            end
            PH_SEND:
            begin
                if (tick_reg == divisor_ext)
                begin
                    tick_next = '0;
                    if (bidx_reg == LAST_BIT)
                    begin
                        if (ptr_reg[PTR_W-1])
                        begin
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            // stop bit, data LSB first, start bit
                            frame_next = {1'b1, rd_char, 1'b0};
                            bidx_next  = '0;
                            ptr_next   = ptr_reg - PTR_W'(1);
                        end
                    end
                    else
                    begin
                        bidx_next  = bidx_reg + BIDX_W'(1);
                        frame_next = frame_reg >> 1;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
                // unused phase holds everything
            end
        endcase
    end

    assign tx_next = frame_next[0];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            tick_reg  <= '0;
            frame_reg <= FRAME_IDLE;
            bidx_reg  <= '0;
            ptr_reg   <= '0;
            value_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            frame_reg <= frame_next;
            bidx_reg  <= bidx_next;
            ptr_reg   <= ptr_next;
            value_reg <= value_next;
        end
    end

    // Character buffer: newline at entry 0, digits above it
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (wr_capture)
            begin
                char_buf_reg[0] <= CHAR_NL;
            end
            if (wr_zero)
            begin
                char_buf_reg[1] <= CHAR_ZERO;
            end
            if (wr_digit && ptr_in_range)
            begin
                char_buf_reg[ptr_reg[BUF_IDX_W-1:0]] <= digit_char;
            end
        end
    end

endmodule
